/* design/pwcmd_pkg.sv */
// ----------------------------------------------------------------------------
// pwcmd_pkg
// Shared types and constants for the one-wire pulse-width command sender.
// ----------------------------------------------------------------------------
package pwcmd_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned IDX_W  = 8;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_HEADER_HIGH = 8'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_LOW  = 8'd1;
  localparam logic [IDX_W-1:0] REG_SHORT_PHASE = 8'd2;
  localparam logic [IDX_W-1:0] REG_LONG_PHASE  = 8'd3;

  localparam logic [TICK_W-1:0] RST_HEADER_HIGH = 16'd8000;
  localparam logic [TICK_W-1:0] RST_HEADER_LOW  = 16'd1000;
  localparam logic [TICK_W-1:0] RST_SHORT_PHASE = 16'd500;
  localparam logic [TICK_W-1:0] RST_LONG_PHASE  = 16'd1500;

  typedef struct packed {
    logic             mode;
    logic [CMD_W-1:0] command;
    logic             busy_pin;
  } in_item_t;

  typedef struct packed {
    logic data_line;
    logic idle;
    logic rejected;
  } out_item_t;

  // Classified beat held between the front end and the sequencer
  typedef struct packed {
    logic             is_request;
    logic [CMD_W-1:0] command;
    logic             busy;
  } q_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] header_high;
    logic [TICK_W-1:0] header_low;
    logic [TICK_W-1:0] short_phase;
    logic [TICK_W-1:0] long_phase;
  } timing_cfg_t;

  // A zero duration lasts one tick
  function automatic logic [TICK_W-1:0] min_one(input logic [TICK_W-1:0] ticks);
    min_one = (ticks == '0) ? TICK_W'(1) : ticks;
  endfunction

endpackage

/* design/pwcmd_front.sv */
// ----------------------------------------------------------------------------
// pwcmd_front
// Input side: takes beats, tags them as tick or send request, and holds them
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module pwcmd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pwcmd_pkg::in_item_t  in_item,
  output logic                 q_valid,
  input  logic                 q_pop,
  output pwcmd_pkg::q_item_t   q_item
);
  import pwcmd_pkg::*;

  q_item_t     entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  q_item_t     classified;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_pop;
  assign q_item   = entries[rd_ptr];

  always_comb begin
    classified.is_request = in_item.mode;
    classified.command    = in_item.command;
    classified.busy       = in_item.busy_pin;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/pwcmd_back.sv */
// ----------------------------------------------------------------------------
// pwcmd_back
// Sequencer: applies one queued beat per cycle, unless the output is stalled,
// to the header/bit phase machine; registers resulting line level and status.
// ----------------------------------------------------------------------------
module pwcmd_back #(
  parameter int unsigned COMMAND_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pwcmd_pkg::timing_cfg_t cfg,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  pwcmd_pkg::q_item_t     q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pwcmd_pkg::out_item_t   out_item
);
  import pwcmd_pkg::*;

  localparam int unsigned BL_W = $clog2(COMMAND_BITS + 1);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WAIT     = 3'd1;
  localparam logic [2:0] PH_HDR_HIGH = 3'd2;
  localparam logic [2:0] PH_HDR_LOW  = 3'd3;
  localparam logic [2:0] PH_BIT_HIGH = 3'd4;
  localparam logic [2:0] PH_BIT_LOW  = 3'd5;

  logic [2:0]              phase, phase_next;
  logic [TICK_W-1:0]       phase_counter, phase_counter_next;
  logic [COMMAND_BITS-1:0] shift_byte, shift_byte_next;
  logic [BL_W-1:0]         bits_left, bits_left_next;
  logic                    line_level, line_level_next;
  logic                    current_bit, current_bit_next;
  logic                    rejected_next;
  logic [TICK_W-1:0]       count_dec;
  logic                    take;

  // Advance when a beat is queued and the output register is free or being drained
  assign take  = q_valid && (!out_valid || out_ready);
  assign q_pop = take;
  assign count_dec = phase_counter - TICK_W'(1);

  always_comb begin
    phase_next         = phase;
    phase_counter_next = phase_counter;
    shift_byte_next    = shift_byte;
    bits_left_next     = bits_left;
    line_level_next    = line_level;
    current_bit_next   = current_bit;
    rejected_next      = 1'b0;

    if (q_item.is_request) begin
      if (phase == PH_IDLE) begin
        shift_byte_next    = COMMAND_BITS'(q_item.command);
        bits_left_next     = BL_W'(COMMAND_BITS);
        phase_next         = PH_WAIT;
        line_level_next    = 1'b0;
        phase_counter_next = '0;
      end else begin
        rejected_next = 1'b1;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
        end
        PH_WAIT: begin
          if (!q_item.busy) begin
            phase_next         = PH_HDR_HIGH;
            line_level_next    = 1'b1;
            phase_counter_next = min_one(cfg.header_high);
          end
        end
        PH_HDR_HIGH, PH_HDR_LOW, PH_BIT_HIGH, PH_BIT_LOW: begin
          phase_counter_next = count_dec;
          if (count_dec == '0) begin
            if (phase == PH_HDR_HIGH) begin
              phase_next         = PH_HDR_LOW;
              line_level_next    = 1'b0;
              phase_counter_next = min_one(cfg.header_low);
            end else if (phase == PH_BIT_HIGH) begin
              phase_next         = PH_BIT_LOW;
              line_level_next    = 1'b0;
              phase_counter_next = min_one(current_bit ? cfg.short_phase
                                                       : cfg.long_phase);
            end else if (bits_left != '0) begin
              // Start the next bit, MSB first
              current_bit_next   = shift_byte[COMMAND_BITS-1];
              shift_byte_next    = shift_byte << 1;
              bits_left_next     = bits_left - BL_W'(1);
              phase_next         = PH_BIT_HIGH;
              line_level_next    = 1'b1;
              phase_counter_next = min_one(shift_byte[COMMAND_BITS-1] ? cfg.long_phase
                                                                     : cfg.short_phase);
            end else begin
              phase_next         = PH_IDLE;
              line_level_next    = 1'b0;
              phase_counter_next = '0;
            end
          end
        end
        default: begin
          phase_next         = PH_IDLE;
          line_level_next    = 1'b0;
          phase_counter_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_counter <= '0;
      shift_byte    <= '0;
      bits_left     <= '0;
      line_level    <= 1'b0;
      current_bit   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        phase_counter <= phase_counter_next;
        shift_byte    <= shift_byte_next;
        bits_left     <= bits_left_next;
        line_level    <= line_level_next;
        current_bit   <= current_bit_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.data_line <= line_level_next;
      out_item.idle      <= (phase_next == PH_IDLE);
      out_item.rejected  <= rejected_next;
    end
  end

endmodule

/* design/pulse_width_one_wire_command_tx.sv */
// One-wire pulse-width command sender. Each input beat is either a time-base
// tick or a request to send a command byte; every beat yields exactly one
// result beat carrying the data line level, the idle flag and a rejected flag
// for requests made while a send is in progress. The block sustains one beat
// per clock on both channels unless the output is stalled: a two-entry queue
// holds accepted beats and the phase sequencer retires one per cycle into an
// output register. The user must write timing registers through the cfg port
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
// pulse_width_one_wire_command_tx
// Top level: timing registers, front-end queue and phase sequencer.
// ----------------------------------------------------------------------------
module pulse_width_one_wire_command_tx #(
  parameter int unsigned COMMAND_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pwcmd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pwcmd_pkg::TICK_W-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pwcmd_pkg::in_item_t                in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pwcmd_pkg::out_item_t               out_item
);
  import pwcmd_pkg::*;

  timing_cfg_t cfg;
  logic        q_valid;
  logic        q_pop;
  q_item_t     q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_high <= RST_HEADER_HIGH;
      cfg.header_low  <= RST_HEADER_LOW;
      cfg.short_phase <= RST_SHORT_PHASE;
      cfg.long_phase  <= RST_LONG_PHASE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_HIGH: cfg.header_high <= cfg_data;
        REG_HEADER_LOW:  cfg.header_low  <= cfg_data;
        REG_SHORT_PHASE: cfg.short_phase <= cfg_data;
        REG_LONG_PHASE:  cfg.long_phase  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwcmd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  pwcmd_back #(
    .COMMAND_BITS (COMMAND_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
